FILE: rtl/core/agms_pkg.sv
package agms_pkg;

    // gain modes
    localparam logic [2:0] MODE_AUTO  = 3'd0;
    localparam logic [2:0] MODE_VHIGH = 3'd1;
    localparam logic [2:0] MODE_HIGH  = 3'd2;
    localparam logic [2:0] MODE_MED   = 3'd3;
    localparam logic [2:0] MODE_LOW   = 3'd4;
    localparam logic [2:0] MODE_VLOW  = 3'd5;

    // item kinds
    localparam logic [1:0] ACT_MEASURE   = 2'd0;
    localparam logic [1:0] ACT_RECOMMEND = 2'd1;
    localparam logic [1:0] ACT_USER      = 2'd2;
    localparam logic [1:0] ACT_AUTO      = 2'd3;

    // converter range codes
    localparam logic [1:0] GAIN_1V024 = 2'd0;
    localparam logic [1:0] GAIN_2V048 = 2'd1;
    localparam logic [1:0] GAIN_4V096 = 2'd2;

    // register map
    localparam int NUM_REGS = 8;
    localparam int REG_IDX_W = 3;
    localparam int PADDR_W = REG_IDX_W + 2;
    localparam logic [REG_IDX_W-1:0] REG_NOISE_LOW      = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_NOISE_VLOW     = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_SNR_UP_HIGH    = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_SNR_UP_VHIGH   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_SNR_KEEP_HIGH  = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_SNR_KEEP_VHIGH = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_HOLD_TIME      = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_AVG_WEIGHT     = 3'd7;

    localparam logic [15:0] REG_RESET [NUM_REGS] = '{
        16'd3072, 16'd7680, 16'd768, 16'd1536, 16'd512, 16'd1152, 16'd1200, 16'd3277
    };

    // Q8.8 stability limits 70.0 and 85.0, noise average floor 0.02
    localparam logic [14:0] STAB_MED   = 15'd17920;
    localparam logic [14:0] STAB_HIGH  = 15'd21760;
    localparam logic [15:0] NOISE_MIN  = 16'd5;
    localparam logic [33:0] ROUND_HALF = 34'd32768;

    typedef struct packed {
        logic [15:0] noise_low_level;
        logic [15:0] noise_very_low_level;
        logic [15:0] snr_up_to_high;
        logic [15:0] snr_up_to_very_high;
        logic [15:0] snr_keep_high;
        logic [15:0] snr_keep_very_high;
        logic [15:0] hold_time_ms;
        logic [15:0] average_weight;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  action;
        logic [2:0]  mode_request;
        logic [15:0] noise_sample;
        logic [15:0] snr_value;
        logic [14:0] stability_pct;
        logic        is_stable;
        logic [31:0] now_ms;
    } in_word_t;

    typedef struct packed {
        logic [2:0]  selected_mode;
        logic [2:0]  active_mode;
        logic        override_on;
        logic [1:0]  gain_code;
        logic        change_event;
        logic [15:0] noise_average;
    } out_word_t;

endpackage

FILE: rtl/core/agms_if.sv
interface agms_in_if;
    logic valid;
    logic ready;
    agms_pkg::in_word_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface agms_out_if;
    logic valid;
    logic ready;
    agms_pkg::out_word_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/core/agms_cfg.sv
module agms_cfg (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [agms_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    output agms_pkg::cfg_t               cfg
);

    logic [15:0] regs_reg [agms_pkg::NUM_REGS];
    logic [agms_pkg::REG_IDX_W-1:0] idx;
    logic wr_en;

    assign idx    = paddr[agms_pkg::PADDR_W-1:2];
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < agms_pkg::NUM_REGS; i++)
            begin
                regs_reg[i] <= agms_pkg::REG_RESET[i];
            end
        end
        else if (wr_en)
        begin
            regs_reg[idx] <= pwdata[15:0];
        end
    end

    assign prdata = {16'd0, regs_reg[idx]};

    assign cfg.noise_low_level      = regs_reg[agms_pkg::REG_NOISE_LOW];
    assign cfg.noise_very_low_level = regs_reg[agms_pkg::REG_NOISE_VLOW];
    assign cfg.snr_up_to_high       = regs_reg[agms_pkg::REG_SNR_UP_HIGH];
    assign cfg.snr_up_to_very_high  = regs_reg[agms_pkg::REG_SNR_UP_VHIGH];
    assign cfg.snr_keep_high        = regs_reg[agms_pkg::REG_SNR_KEEP_HIGH];
    assign cfg.snr_keep_very_high   = regs_reg[agms_pkg::REG_SNR_KEEP_VHIGH];
    assign cfg.hold_time_ms         = regs_reg[agms_pkg::REG_HOLD_TIME];
    assign cfg.average_weight       = regs_reg[agms_pkg::REG_AVG_WEIGHT];

endmodule

FILE: rtl/core/agms_core.sv
module agms_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  agms_pkg::in_word_t  word,
    input  agms_pkg::cfg_t      cfg,
    output agms_pkg::out_word_t result_next
);

    logic [2:0]  mode_selected_reg, mode_selected_next;
    logic [2:0]  mode_active_reg, mode_active_next;
    logic [2:0]  mode_recommended_reg, mode_recommended_next;
    logic        user_fixed_reg, user_fixed_next;
    logic        engine_started_reg, engine_started_next;
    logic [15:0] noise_avg_reg, noise_avg_next;
    logic [2:0]  mode_last_reg, mode_last_next;
    logic [31:0] last_change_reg, last_change_next;

    logic [2:0]         req;
    logic [2:0]         req_eff;
    logic [2:0]         auto_eff_new_rec;
    logic [2:0]         auto_eff_old_rec;
    logic signed [16:0] diff;
    logic signed [33:0] prod;
    logic signed [33:0] prod_rnd;
    logic [17:0]        avg_sum;
    logic [15:0]        avg_upd;
    logic [31:0]        elapsed;
    logic               hold_done;
    logic [2:0]         target;
    logic               event_flag;
    logic [1:0]         gain;

    // requests beyond very low mean medium
    assign req = (word.mode_request > agms_pkg::MODE_VLOW) ? agms_pkg::MODE_MED
                                                           : word.mode_request;

    // effective mode when auto is applied
    assign auto_eff_new_rec = (req == agms_pkg::MODE_AUTO) ? agms_pkg::MODE_MED : req;
    assign auto_eff_old_rec = (mode_recommended_reg == agms_pkg::MODE_AUTO) ?
                              agms_pkg::MODE_MED : mode_recommended_reg;
    assign req_eff = (req == agms_pkg::MODE_AUTO) ? auto_eff_old_rec : req;

    // ema as avg + w * (nf - avg), rounded half up
    assign diff     = $signed({1'b0, word.noise_sample}) - $signed({1'b0, noise_avg_reg});
    assign prod     = $signed({1'b0, cfg.average_weight}) * diff;
    assign prod_rnd = prod + $signed(agms_pkg::ROUND_HALF);
    assign avg_sum  = {2'b00, noise_avg_reg} + prod_rnd[33:16];
    assign avg_upd  = (avg_sum[15:0] < agms_pkg::NOISE_MIN) ? agms_pkg::NOISE_MIN
                                                            : avg_sum[15:0];

    assign elapsed   = word.now_ms - last_change_reg;
    assign hold_done = elapsed >= {16'd0, cfg.hold_time_ms};

    // hysteresis decision from the last applied mode
    always_comb
    begin
        if (avg_upd >= cfg.noise_very_low_level)
        begin
            target = agms_pkg::MODE_VLOW;
        end
        else if (avg_upd >= cfg.noise_low_level)
        begin
            target = agms_pkg::MODE_LOW;
        end
        else if (mode_last_reg == agms_pkg::MODE_VHIGH)
        begin
            if (word.snr_value < cfg.snr_keep_very_high
                || word.stability_pct < agms_pkg::STAB_HIGH)
            begin
                if (word.snr_value >= cfg.snr_keep_high
                    && word.stability_pct >= agms_pkg::STAB_MED)
                begin
                    target = agms_pkg::MODE_HIGH;
                end
                else
                begin
                    target = agms_pkg::MODE_MED;
                end
            end
            else
            begin
                target = agms_pkg::MODE_VHIGH;
            end
        end
        else if (mode_last_reg == agms_pkg::MODE_HIGH)
        begin
            if (word.snr_value < cfg.snr_keep_high || word.stability_pct < agms_pkg::STAB_MED)
            begin
                target = agms_pkg::MODE_MED;
            end
            else if (word.snr_value >= cfg.snr_up_to_very_high
                     && word.stability_pct >= agms_pkg::STAB_HIGH)
            begin
                target = agms_pkg::MODE_VHIGH;
            end
            else
            begin
                target = agms_pkg::MODE_HIGH;
            end
        end
        else if (mode_last_reg == agms_pkg::MODE_LOW)
        begin
            target = agms_pkg::MODE_MED;
        end
        else if (word.snr_value >= cfg.snr_up_to_very_high
                 && word.stability_pct >= agms_pkg::STAB_HIGH)
        begin
            target = agms_pkg::MODE_VHIGH;
        end
        else if (word.snr_value >= cfg.snr_up_to_high
                 && word.stability_pct >= agms_pkg::STAB_MED)
        begin
            target = agms_pkg::MODE_HIGH;
        end
        else
        begin
            target = agms_pkg::MODE_MED;
        end
    end

    always_comb
    begin
        mode_selected_next    = mode_selected_reg;
        mode_active_next      = mode_active_reg;
        mode_recommended_next = mode_recommended_reg;
        user_fixed_next       = user_fixed_reg;
        engine_started_next   = engine_started_reg;
        noise_avg_next        = noise_avg_reg;
        mode_last_next        = mode_last_reg;
        last_change_next      = last_change_reg;
        event_flag            = 1'b0;

        unique case (word.action)
            agms_pkg::ACT_MEASURE:
            begin
                if (!user_fixed_reg && mode_selected_reg == agms_pkg::MODE_AUTO)
                begin
                    if (!engine_started_reg)
                    begin
                        noise_avg_next      = word.noise_sample;
                        mode_last_next      = mode_active_reg;
                        last_change_next    = word.now_ms;
                        engine_started_next = 1'b1;
                    end
                    else
                    begin
                        noise_avg_next = avg_upd;
                        if (word.is_stable && hold_done && target != mode_last_reg)
                        begin
                            mode_selected_next = target;
                            mode_active_next   = target;
                            mode_last_next     = target;
                            last_change_next   = word.now_ms;
                            event_flag         = 1'b1;
                        end
                    end
                end
            end
            agms_pkg::ACT_RECOMMEND:
            begin
                mode_recommended_next = req;
                if (!user_fixed_reg)
                begin
                    mode_selected_next = req;
                    mode_active_next   = auto_eff_new_rec;
                    event_flag         = 1'b1;
                end
            end
            agms_pkg::ACT_USER:
            begin
                user_fixed_next    = (req != agms_pkg::MODE_AUTO);
                mode_selected_next = req;
                mode_active_next   = req_eff;
                if (req != agms_pkg::MODE_AUTO)
                begin
                    mode_last_next   = req_eff;
                    last_change_next = word.now_ms;
                end
                event_flag = 1'b1;
            end
            agms_pkg::ACT_AUTO:
            begin
                user_fixed_next    = 1'b0;
                mode_last_next     = mode_active_reg;
                mode_selected_next = agms_pkg::MODE_AUTO;
                mode_active_next   = auto_eff_old_rec;
                event_flag         = 1'b1;
            end
            default:
            begin
                event_flag = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        if (mode_active_next <= agms_pkg::MODE_HIGH)
        begin
            gain = agms_pkg::GAIN_1V024;
        end
        else if (mode_active_next == agms_pkg::MODE_MED)
        begin
            gain = agms_pkg::GAIN_2V048;
        end
        else
        begin
            gain = agms_pkg::GAIN_4V096;
        end
    end

    assign result_next.selected_mode = mode_selected_next;
    assign result_next.active_mode   = mode_active_next;
    assign result_next.override_on   = user_fixed_next;
    assign result_next.gain_code     = gain;
    assign result_next.change_event  = event_flag;
    assign result_next.noise_average = noise_avg_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_selected_reg    <= agms_pkg::MODE_MED;
            mode_active_reg      <= agms_pkg::MODE_MED;
            mode_recommended_reg <= agms_pkg::MODE_MED;
            user_fixed_reg       <= 1'b0;
            engine_started_reg   <= 1'b0;
            noise_avg_reg        <= 16'd0;
            mode_last_reg        <= agms_pkg::MODE_MED;
            last_change_reg      <= 32'd0;
        end
        else if (advance)
        begin
            mode_selected_reg    <= mode_selected_next;
            mode_active_reg      <= mode_active_next;
            mode_recommended_reg <= mode_recommended_next;
            user_fixed_reg       <= user_fixed_next;
            engine_started_reg   <= engine_started_next;
            noise_avg_reg        <= noise_avg_next;
            mode_last_reg        <= mode_last_next;
            last_change_reg      <= last_change_next;
        end
    end

    // the effective mode is never auto
    a_active_not_auto: assert property (@(posedge clk) disable iff (!rst_n)
        mode_active_reg != agms_pkg::MODE_AUTO && mode_active_reg <= agms_pkg::MODE_VLOW)
        else $error("active mode out of range");

    // a user-fixed mode is never auto
    a_fixed_not_auto: assert property (@(posedge clk) disable iff (!rst_n)
        user_fixed_reg |-> mode_selected_reg != agms_pkg::MODE_AUTO)
        else $error("override held with auto selected");

    // the average engine never stops once started
    a_engine_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        engine_started_reg |=> engine_started_reg)
        else $error("engine start flag cleared");

    // an automatic change event sets the selected mode off auto and last mode to active
    a_event_measure: assert property (@(posedge clk) disable iff (!rst_n)
        advance && word.action == agms_pkg::ACT_MEASURE && event_flag
        |=> mode_selected_reg != agms_pkg::MODE_AUTO && mode_last_reg == mode_active_reg)
        else $error("automatic change left inconsistent state");

endmodule

FILE: rtl/core/adaptive_gain_mode_selector_top.sv
// adaptive gain mode selector
//
// item channel (sink): one word per command - measurement, recommendation,
// user select or return to auto. result channel (source): one word per
// accepted item with the selected and active mode, override flag, converter
// gain code, change-event flag and the averaged noise value
// apb port: eight 16-bit registers at byte offsets 0x00..0x1c, pready tied
// high; writes only while no item is in flight (user's rule, not enforced)
// path: an accepted word is captured in the input register, evaluated from
// there when the output register is free or draining, and its result is
// loaded into the output register, where the receiver can take it
// throughput: one word per cycle while results are taken, set by the single
// pass through the noise average multiplier and the hysteresis compare logic
// reset: registers return to their defaults, mode is medium, override off,
// noise average zero and the average engine not yet started
// stall: a result held by the receiver stays in the output register; the
// input register still takes one more word, after which ready drops until
// the result is taken
module adaptive_gain_mode_selector_top (
    input  logic                         clk,
    input  logic                         rst_n,
    agms_in_if.sink                      item,
    agms_out_if.source                   result,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [agms_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    agms_pkg::cfg_t      cfg;
    agms_pkg::in_word_t  in_data_reg;
    agms_pkg::out_word_t out_data_reg;
    agms_pkg::out_word_t result_next;
    logic                in_valid_reg, in_valid_next;
    logic                out_valid_reg, out_valid_next;
    logic                advance;
    logic                take;

    agms_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // evaluate the captured word when the output register is free or draining
    assign advance    = in_valid_reg && (!out_valid_reg || result.ready);
    assign item.ready = !in_valid_reg || advance;
    assign take       = item.valid && item.ready;

    agms_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .word        (in_data_reg),
        .cfg         (cfg),
        .result_next (result_next)
    );

    always_comb
    begin
        in_valid_next  = take || (in_valid_reg && !advance);
        out_valid_next = advance || (out_valid_reg && !result.ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, loaded only on a transfer
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_data_reg <= item.data;
        end
        if (advance)
        begin
            out_data_reg <= result_next;
        end
    end

    assign result.valid = out_valid_reg;
    assign result.data  = out_data_reg;

    // an accepted word is always held for evaluation
    a_take_held: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> in_valid_reg)
        else $error("accepted word lost");

    // a stalled result keeps the pending word waiting
    a_stall_waits: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && out_valid_reg && !result.ready |=> in_valid_reg && out_valid_reg)
        else $error("word dropped under stall");

endmodule

FILE: tb/gain_mode_checker.sv
module gain_mode_checker
    import agms_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    agms_in_if                  item,
    agms_out_if                 result,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic                pready,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [31:0]         pwdata,
    output int                  failures,
    output int                  pending,
    output int                  results_checked,
    output int                  change_events
);
    timeunit 1ns;
    timeprecision 1ps;

    // register copy and selector state
    logic [15:0] cfg_regs [NUM_REGS];
    logic [2:0]  mode_sel;
    logic [2:0]  mode_act;
    logic [2:0]  mode_rec;
    logic        fixed_by_user;
    logic        avg_running;
    logic [15:0] avg_noise;
    logic [2:0]  mode_prev;
    logic [31:0] stamp_ms;

    out_word_t   expected_words [$];
    int          mismatch_total;
    int          checked_total;
    int          event_total;

    task automatic report_mismatch(input string what);
        $display("[%0t] result %0d: %s", $realtime, checked_total, what);
        mismatch_total++;
    endtask

    function automatic logic [2:0] resolve_active(input logic [2:0] m);
        logic [2:0] eff;
        eff = m;
        if (eff == MODE_AUTO)
            eff = (mode_rec == MODE_AUTO) ? MODE_MED : mode_rec;
        if (eff > MODE_VLOW)
            eff = MODE_MED;
        return eff;
    endfunction

    function automatic void set_mode(input logic [2:0] m);
        mode_act = resolve_active(m);
        mode_sel = m;
    endfunction

    function automatic logic [2:0] pick_target(input logic [15:0] avg, input logic [15:0] snr,
                                               input logic [14:0] stab, input logic [2:0] cur);
        if (avg >= cfg_regs[REG_NOISE_VLOW])
            return MODE_VLOW;
        if (avg >= cfg_regs[REG_NOISE_LOW])
            return MODE_LOW;
        if (cur == MODE_VHIGH)
        begin
            if (snr < cfg_regs[REG_SNR_KEEP_VHIGH] || stab < STAB_HIGH)
            begin
                if (snr >= cfg_regs[REG_SNR_KEEP_HIGH] && stab >= STAB_MED)
                    return MODE_HIGH;
                return MODE_MED;
            end
            return MODE_VHIGH;
        end
        if (cur == MODE_HIGH)
        begin
            if (snr < cfg_regs[REG_SNR_KEEP_HIGH] || stab < STAB_MED)
                return MODE_MED;
            if (snr >= cfg_regs[REG_SNR_UP_VHIGH] && stab >= STAB_HIGH)
                return MODE_VHIGH;
            return MODE_HIGH;
        end
        if (cur == MODE_LOW)
            return MODE_MED;
        // medium and very low share the upward path
        if (snr >= cfg_regs[REG_SNR_UP_VHIGH] && stab >= STAB_HIGH)
            return MODE_VHIGH;
        if (snr >= cfg_regs[REG_SNR_UP_HIGH] && stab >= STAB_MED)
            return MODE_HIGH;
        return MODE_MED;
    endfunction

    function automatic out_word_t advance_selector(input in_word_t w);
        logic [2:0]  m;
        logic [2:0]  target;
        logic        ev;
        logic [16:0] keep;
        logic [47:0] acc;
        logic [31:0] since;
        out_word_t   r;
        m = w.mode_request;
        if (m > MODE_VLOW)
            m = MODE_MED;
        ev = 1'b0;
        case (w.action)
            ACT_MEASURE:
            begin
                if (!fixed_by_user && mode_sel == MODE_AUTO)
                begin
                    if (!avg_running)
                    begin
                        avg_noise   = w.noise_sample;
                        mode_prev   = mode_act;
                        stamp_ms    = w.now_ms;
                        avg_running = 1'b1;
                    end
                    else
                    begin
                        keep = 17'h10000 - 17'(cfg_regs[REG_AVG_WEIGHT]);
                        acc  = 48'(keep) * 48'(avg_noise)
                             + 48'(cfg_regs[REG_AVG_WEIGHT]) * 48'(w.noise_sample)
                             + 48'd32768;
                        avg_noise = acc[31:16];
                        if (avg_noise < NOISE_MIN)
                            avg_noise = NOISE_MIN;
                        since = w.now_ms - stamp_ms;
                        if (w.is_stable && since >= {16'd0, cfg_regs[REG_HOLD_TIME]})
                        begin
                            target = pick_target(avg_noise, w.snr_value, w.stability_pct,
                                                 mode_prev);
                            if (target != mode_prev)
                            begin
                                set_mode(target);
                                mode_prev = target;
                                stamp_ms  = w.now_ms;
                                ev        = 1'b1;
                            end
                        end
                    end
                end
            end
            ACT_RECOMMEND:
            begin
                mode_rec = m;
                if (!fixed_by_user)
                begin
                    set_mode(m);
                    ev = 1'b1;
                end
            end
            ACT_USER:
            begin
                fixed_by_user = (m != MODE_AUTO);
                set_mode(m);
                if (fixed_by_user)
                begin
                    mode_prev = mode_act;
                    stamp_ms  = w.now_ms;
                end
                ev = 1'b1;
            end
            default:
            begin
                fixed_by_user = 1'b0;
                mode_prev     = mode_act;
                set_mode(MODE_AUTO);
                ev = 1'b1;
            end
        endcase
        r.selected_mode = mode_sel;
        r.active_mode   = mode_act;
        r.override_on   = fixed_by_user;
        if (mode_act <= MODE_HIGH)
            r.gain_code = GAIN_1V024;
        else if (mode_act == MODE_MED)
            r.gain_code = GAIN_2V048;
        else
            r.gain_code = GAIN_4V096;
        r.change_event  = ev;
        r.noise_average = avg_noise;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        out_word_t want;
        out_word_t got;
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
                cfg_regs[i] = REG_RESET[i];
            mode_sel      = MODE_MED;
            mode_act      = MODE_MED;
            mode_rec      = MODE_MED;
            fixed_by_user = 1'b0;
            avg_running   = 1'b0;
            avg_noise     = '0;
            mode_prev     = MODE_MED;
            stamp_ms      = '0;
            expected_words.delete();
            failures        <= 0;
            pending         <= 0;
            results_checked <= 0;
            change_events   <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
                cfg_regs[paddr[PADDR_W-1:2]] = pwdata[15:0];
            if (result.valid && result.ready)
            begin
                got = result.data;
                if (expected_words.size() == 0)
                    report_mismatch("result word with nothing expected");
                else
                begin
                    want = expected_words.pop_front();
                    if (got.selected_mode !== want.selected_mode)
                        report_mismatch($sformatf("selected_mode %0d, expected %0d",
                                                  got.selected_mode, want.selected_mode));
                    if (got.active_mode !== want.active_mode)
                        report_mismatch($sformatf("active_mode %0d, expected %0d",
                                                  got.active_mode, want.active_mode));
                    if (got.override_on !== want.override_on)
                        report_mismatch($sformatf("override_on %0d, expected %0d",
                                                  got.override_on, want.override_on));
                    if (got.gain_code !== want.gain_code)
                        report_mismatch($sformatf("gain_code %0d, expected %0d",
                                                  got.gain_code, want.gain_code));
                    if (got.change_event !== want.change_event)
                        report_mismatch($sformatf("change_event %0d, expected %0d",
                                                  got.change_event, want.change_event));
                    if (got.noise_average !== want.noise_average)
                        report_mismatch($sformatf("noise_average %0d, expected %0d",
                                                  got.noise_average, want.noise_average));
                    if (want.change_event)
                        event_total++;
                end
                checked_total++;
            end
            if (item.valid && item.ready)
                expected_words.push_back(advance_selector(item.data));
            failures        <= mismatch_total;
            pending         <= expected_words.size();
            results_checked <= checked_total;
            change_events   <= event_total;
        end
    end

endmodule

FILE: tb/testbench.sv
module testbench;
    import agms_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // register setting styles used between traffic phases
    typedef enum int {
        SET_FAST,
        SET_RANDOM,
        SET_ZERO,
        SET_FULL,
        SET_DEFAULT
    } setting_kind_t;

    localparam int PHASE_COUNT  = 6;
    localparam int PHASE_WORDS  = 330;
    localparam int HOLD_OFF_LEN = 300;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    int failures;
    int pending;
    int results_checked;
    int change_events;

    agms_in_if  item_ch ();
    agms_out_if result_ch ();

    adaptive_gain_mode_selector_top i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item_ch),
        .result  (result_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // watches both channels and the register port, predicts every result word
    gain_mode_checker i_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .item            (item_ch),
        .result          (result_ch),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .pready          (pready),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .failures        (failures),
        .pending         (pending),
        .results_checked (results_checked),
        .change_events   (change_events)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // stimulus-side copy of the registers, used to aim values at thresholds
    logic [15:0]   cfg_shadow [NUM_REGS];
    logic [31:0]   clock_ms;
    int            burst_left;
    int            words_sent;
    int            settings_used;
    logic          hold_tgl;
    setting_kind_t phase_plan [PHASE_COUNT];

    // ------------------------------------------------------------------
    // sender: words go out in bursts, with random gaps between bursts;
    // valid stays high across back-to-back words
    // ------------------------------------------------------------------
    task automatic send_word(input in_word_t word);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            // about a third of the bursts follow the last one with no gap
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                item_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        item_ch.valid <= 1'b1;
        item_ch.data  <= word;
        do
            @(posedge clk);
        while (!item_ch.ready);
        words_sent++;
    endtask

    task automatic send_fields(input logic [1:0] action, input logic [2:0] mode,
                               input logic [15:0] noise, input logic [15:0] snr,
                               input logic [14:0] stab, input logic stable,
                               input logic [31:0] now);
        in_word_t word;
        word.action        = action;
        word.mode_request  = mode;
        word.noise_sample  = noise;
        word.snr_value     = snr;
        word.stability_pct = stab;
        word.is_stable     = stable;
        word.now_ms        = now;
        send_word(word);
    endtask

    // drop valid and wait until every predicted word has come back
    task automatic wait_idle();
        item_ch.valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // apb write: setup phase, then access phase until pready; the caller
    // drops psel after the last write so writes can follow back to back
    task automatic write_register(input logic [2:0] idx, input logic [15:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        // upper data bits carry junk, the block keeps only the low 16
        pwdata  <= {16'($urandom), value};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        cfg_shadow[idx] = value;
    endtask

    task automatic load_setting(input setting_kind_t kind);
        logic [15:0] vals [NUM_REGS];
        logic [15:0] base;
        for (int i = 0; i < NUM_REGS; i++)
            vals[i] = REG_RESET[i];
        case (kind)
            SET_FAST:
            begin
                // no hold time and an average that follows the latest sample
                vals[REG_HOLD_TIME]  = 16'd0;
                vals[REG_AVG_WEIGHT] = 16'hffff;
            end
            SET_ZERO:
                for (int i = 0; i < NUM_REGS; i++)
                    vals[i] = 16'd0;
            SET_FULL:
                for (int i = 0; i < NUM_REGS; i++)
                    vals[i] = 16'hffff;
            SET_RANDOM:
            begin
                vals[REG_NOISE_LOW]      = 16'($urandom_range(256, 6000));
                vals[REG_NOISE_VLOW]     = vals[REG_NOISE_LOW] + 16'($urandom_range(256, 8000));
                base                     = 16'($urandom_range(256, 2048));
                vals[REG_SNR_UP_HIGH]    = base;
                vals[REG_SNR_UP_VHIGH]   = base + 16'($urandom_range(0, 1024));
                vals[REG_SNR_KEEP_HIGH]  = 16'($urandom_range(0, base));
                vals[REG_SNR_KEEP_VHIGH] = 16'($urandom_range(vals[REG_SNR_KEEP_HIGH],
                                                              vals[REG_SNR_UP_VHIGH]));
                vals[REG_HOLD_TIME]      = 16'($urandom_range(0, 3000));
                vals[REG_AVG_WEIGHT]     = 16'($urandom_range(1000, 65535));
            end
            default:
            begin
            end
        endcase
        for (int i = 0; i < NUM_REGS; i++)
            write_register(3'(i), vals[i]);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        settings_used++;
    endtask

    // ------------------------------------------------------------------
    // field shaping: many values sit near the thresholds in force
    // ------------------------------------------------------------------
    function automatic logic [15:0] near_level(input int level);
        int v;
        v = level + $urandom_range(0, 16) - 8;
        if (v < 0)
            v = 0;
        if (v > 65535)
            v = 65535;
        return 16'(v);
    endfunction

    function automatic logic [15:0] pick_noise();
        int r;
        r = $urandom_range(0, 9);
        if (r <= 3)
            return 16'($urandom_range(0, cfg_shadow[REG_NOISE_LOW]));
        if (r <= 5)
            return near_level(cfg_shadow[REG_NOISE_LOW]);
        if (r <= 7)
            return near_level(cfg_shadow[REG_NOISE_VLOW]);
        if (r == 8)
            return 16'($urandom_range(0, 65535));
        return ($urandom_range(0, 1) == 1) ? 16'hffff : 16'h0000;
    endfunction

    function automatic logic [15:0] pick_snr();
        int r;
        r = $urandom_range(0, 5);
        if (r <= 3)
            return near_level(cfg_shadow[REG_SNR_UP_HIGH + r]);
        if (r == 4)
            return 16'($urandom_range(0, 65535));
        return 16'($urandom_range(0, 4096));
    endfunction

    function automatic logic [14:0] pick_stab();
        int r;
        r = $urandom_range(0, 9);
        if (r <= 1)
            return 15'(near_level(STAB_MED));
        if (r <= 3)
            return 15'(near_level(STAB_HIGH));
        if (r <= 5)
            return 15'($urandom_range(0, 25600));
        if (r <= 8)
            return 15'($urandom_range(STAB_HIGH, 25600));
        return 15'($urandom_range(0, 32767));
    endfunction

    // time moves mostly around the hold time, now and then a big jump
    task automatic advance_clock();
        int hold;
        int r;
        hold = cfg_shadow[REG_HOLD_TIME];
        r = $urandom_range(0, 19);
        if (r <= 3)
            clock_ms = clock_ms + 32'($urandom_range(0, hold / 4));
        else if (r <= 13)
            clock_ms = clock_ms + 32'($urandom_range((hold > 2) ? hold - 2 : 0, hold + 2));
        else if (r <= 18)
            clock_ms = clock_ms + 32'($urandom_range(hold, 2 * hold + 100));
        else
            clock_ms = clock_ms + $urandom;
    endtask

    task automatic send_measurement(input logic stable);
        advance_clock();
        send_fields(ACT_MEASURE, 3'($urandom_range(0, 7)), pick_noise(), pick_snr(),
                    pick_stab(), stable, clock_ms);
    endtask

    task automatic send_noise_word();
        in_word_t word;
        word.action        = 2'($urandom_range(0, 3));
        word.mode_request  = 3'($urandom_range(0, 7));
        word.noise_sample  = 16'($urandom);
        word.snr_value     = 16'($urandom);
        word.stability_pct = 15'($urandom);
        word.is_stable     = 1'($urandom);
        word.now_ms        = $urandom;
        send_word(word);
    endtask

    // usually back to auto, then a run of measurements that the engine acts on
    task automatic auto_run();
        int n;
        if ($urandom_range(0, 9) != 0)
            send_fields(ACT_AUTO, 3'($urandom_range(0, 7)), 16'($urandom), 16'($urandom),
                        15'($urandom), 1'($urandom), clock_ms);
        n = $urandom_range(3, 20);
        repeat (n)
            send_measurement($urandom_range(0, 19) < 17);
    endtask

    task automatic random_traffic(input int stop_at);
        int r;
        while (words_sent < stop_at)
        begin
            r = $urandom_range(0, 99);
            if (r < 60)
                auto_run();
            else if (r < 70)
                send_fields(ACT_RECOMMEND, 3'($urandom_range(0, 7)), pick_noise(), pick_snr(),
                            pick_stab(), 1'($urandom), clock_ms);
            else if (r < 78)
                send_fields(ACT_USER,
                            ($urandom_range(0, 2) == 0) ? MODE_AUTO : 3'($urandom_range(0, 7)),
                            pick_noise(), pick_snr(), pick_stab(), 1'($urandom), clock_ms);
            else if (r < 85)
                send_noise_word();
            else
                send_measurement(1'b1);
        end
    endtask

    // ------------------------------------------------------------------
    // receiver: stall style changes every window; a toggle of hold_tgl
    // makes it hold off for a long stretch so the block backs up
    // ------------------------------------------------------------------
    initial
    begin
        int   hold_left;
        int   window_left;
        int   stall_style;
        logic hold_seen;
        hold_left   = 0;
        window_left = 0;
        stall_style = 0;
        hold_seen   = 1'b0;
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_tgl != hold_seen)
            begin
                hold_seen = hold_tgl;
                hold_left = HOLD_OFF_LEN;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end
            else
            begin
                if (window_left == 0)
                begin
                    window_left = $urandom_range(16, 64);
                    stall_style = $urandom_range(0, 3);
                end
                window_left--;
                case (stall_style)
                    0: result_ch.ready <= 1'b1;
                    1: result_ch.ready <= 1'($urandom_range(0, 1));
                    2: result_ch.ready <= (window_left % 4 == 0);
                    default: result_ch.ready <= ($urandom_range(0, 9) != 0);
                endcase
            end
        end
    end

    // run limit, far above the slowest legal run
    initial
    begin
        #4_000_000;
        $display("timeout after %0d words sent", words_sent);
        $display("end of test: mismatches");
        $finish;
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n         <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        item_ch.valid <= 1'b0;
        item_ch.data  <= '0;
        hold_tgl      <= 1'b0;
        for (int i = 0; i < NUM_REGS; i++)
            cfg_shadow[i] = REG_RESET[i];
        burst_left    = 0;
        words_sent    = 0;
        settings_used = 1;
        phase_plan    = '{SET_FAST, SET_RANDOM, SET_ZERO, SET_FULL, SET_RANDOM, SET_DEFAULT};

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part on reset registers
        // measurement while medium is selected is ignored
        send_fields(ACT_MEASURE, MODE_AUTO, 16'h0100, 16'd0, 15'd0, 1'b1, 32'd100);
        // recommending auto falls back to medium as the effective mode
        send_fields(ACT_RECOMMEND, MODE_AUTO, 16'd0, 16'd0, 15'd0, 1'b0, 32'd200);
        // first measurement seeds the average unclamped
        send_fields(ACT_MEASURE, MODE_AUTO, 16'd2, 16'd0, 15'd0, 1'b1, 32'd1000);
        // unstable, average clamps up to the floor
        send_fields(ACT_MEASURE, MODE_AUTO, 16'd0, 16'hffff, 15'h7fff, 1'b0, 32'd1100);
        // inside the hold time
        send_fields(ACT_MEASURE, MODE_AUTO, 16'h0100, 16'hffff, 15'h7fff, 1'b1, 32'd1500);
        // exactly at the hold time, medium rises straight to very high
        send_fields(ACT_MEASURE, MODE_AUTO, 16'd0, 16'hffff, 15'h7fff, 1'b1, 32'd2200);
        // auto change left mode selected, so this one is ignored
        send_fields(ACT_MEASURE, MODE_AUTO, 16'd0, 16'd0, 15'd0, 1'b1, 32'd9000);
        send_fields(ACT_AUTO, MODE_AUTO, 16'd0, 16'd0, 15'd0, 1'b0, 32'd2400);
        // very high steps down to high
        send_fields(ACT_MEASURE, MODE_AUTO, 16'd0, 16'd1000, 15'd20000, 1'b1, 32'd3400);
        send_fields(ACT_AUTO, MODE_AUTO, 16'd0, 16'd0, 15'd0, 1'b0, 32'd3500);
        // high rises to very high, time stamp just before the wrap
        send_fields(ACT_MEASURE, MODE_AUTO, 16'd0, 16'd1536, 15'(STAB_HIGH), 1'b1,
                    32'hffff_fd00);
        send_fields(ACT_AUTO, MODE_AUTO, 16'd0, 16'd0, 15'd0, 1'b0, 32'hffff_fe00);
        // elapsed time across the wrap, very high drops to medium
        send_fields(ACT_MEASURE, MODE_AUTO, 16'd0, 16'd0, 15'd0, 1'b1, 32'h0000_0200);
        clock_ms = 32'h0000_0200;
        send_fields(ACT_AUTO, MODE_AUTO, 16'd0, 16'd0, 15'd0, 1'b0, clock_ms);
        // loud noise pushes the average into low, then very low
        clock_ms = clock_ms + 32'd1200;
        send_fields(ACT_MEASURE, MODE_AUTO, 16'hffff, 16'd0, 15'd0, 1'b1, clock_ms);
        send_fields(ACT_AUTO, MODE_AUTO, 16'd0, 16'd0, 15'd0, 1'b0, clock_ms);
        clock_ms = clock_ms + 32'd1200;
        send_fields(ACT_MEASURE, MODE_AUTO, 16'hffff, 16'd0, 15'd0, 1'b1, clock_ms);
        clock_ms = clock_ms + 32'd1200;
        send_fields(ACT_MEASURE, MODE_AUTO, 16'hffff, 16'd0, 15'd0, 1'b1, clock_ms);
        // user choice 7 means medium and fixes the mode
        send_fields(ACT_USER, 3'd7, 16'd0, 16'd0, 15'd0, 1'b0, clock_ms);
        // recommendation while fixed: stored, no event
        send_fields(ACT_RECOMMEND, MODE_VHIGH, 16'd0, 16'd0, 15'd0, 1'b0, clock_ms);
        send_fields(ACT_MEASURE, MODE_AUTO, 16'hffff, 16'hffff, 15'h7fff, 1'b1, 32'hffff_ffff);
        // user choice of auto releases the fix, recommended mode takes over
        send_fields(ACT_USER, MODE_AUTO, 16'd0, 16'd0, 15'd0, 1'b0, clock_ms);
        send_fields(ACT_RECOMMEND, 3'd6, 16'd0, 16'd0, 15'd0, 1'b0, clock_ms);
        send_fields(ACT_USER, MODE_VLOW, 16'd0, 16'd0, 15'd0, 1'b0, clock_ms);
        send_fields(ACT_AUTO, MODE_LOW, 16'd0, 16'd0, 15'd0, 1'b0, clock_ms);
        wait_idle();

        // random phases, each under its own register setting
        clock_ms = $urandom;
        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            load_setting(phase_plan[p]);
            random_traffic(words_sent + 60);
            // long receiver hold-off while words keep coming
            hold_tgl <= ~hold_tgl;
            random_traffic(words_sent + PHASE_WORDS - 60);
            wait_idle();
        end

        $display("covered %0d words under %0d register settings, incl. zero and full ranges",
                 words_sent, settings_used);
        $display("%0d results checked, %0d mode change events", results_checked, change_events);
        if (failures == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
